// ----- design/swrm_pkg.sv -----
// shared types and constants of the sliding window rate meter
`timescale 1ns / 1ps

package swrm_pkg;

  // field widths
  localparam int WINDOW_W    = 6;
  localparam int MSG_BYTES_W = 24;
  localparam int CNT_W       = 32;
  localparam int BYTE_W      = 48;
  localparam int MSG_RATE_W  = 40;
  localparam int BYTE_RATE_W = 56;
  localparam int Q_FRAC      = 8;

  // divider: one quotient bit per cycle over the widest dividend
  localparam int DIV_W     = BYTE_W + Q_FRAC;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // request codes
  localparam logic REQ_MSG  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // one per-tick bin as stored in the ring memory
  typedef struct packed {
    logic [BYTE_W-1:0] byte_cnt;
    logic [CNT_W-1:0]  msg_cnt;
  } bin_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_TICK_SUM,
    ST_TICK_TAIL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- design/swrm_in_if.sv -----
// request channel: message arrivals and ticks
`timescale 1ns / 1ps

interface swrm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [swrm_pkg::MSG_BYTES_W-1:0] msg_bytes;

  modport source (output valid, output req_type, output msg_bytes, input ready);
  modport sink   (input valid, input req_type, input msg_bytes, output ready);
endinterface

// ----- design/swrm_out_if.sv -----
// result channel: window totals and rates
`timescale 1ns / 1ps

interface swrm_out_if;
  logic                             valid;
  logic                             ready;
  logic [swrm_pkg::CNT_W-1:0]       msg_total;
  logic [swrm_pkg::BYTE_W-1:0]      byte_total;
  logic [swrm_pkg::MSG_RATE_W-1:0]  msg_rate_q8;
  logic [swrm_pkg::BYTE_RATE_W-1:0] byte_rate_q8;
  logic                             window_full;

  modport source (output valid, output msg_total, output byte_total, output msg_rate_q8,
                  output byte_rate_q8, output window_full, input ready);
  modport sink   (input valid, input msg_total, input byte_total, input msg_rate_q8,
                  input byte_rate_q8, input window_full, output ready);
endinterface

// ----- design/sliding_window_rate_meter_unit.sv -----
// sliding window rate meter: ring of per-tick bins in memory, running sums, rate divider
`timescale 1ns / 1ps

// Usage
//   item (sink): req_type 0 adds one message of msg_bytes to the current bin;
//     req_type 1 closes the current tick and produces one result transaction.
//   result (source): window totals, Q8 rates (total * 256 / window) and window_full.
//   cfg_we / cfg_wdata: writes the window length (0 reads as 1, values above
//     MAX_WINDOW saturate) and clears bins, sums and the tick count; write only
//     while the block is idle.
// Timing
//   A message reads its bin from the ring memory, then the saturating add is
//   written back. It produces no result.
//   A tick runs to the result register through sum update,
//   tail subtract, then a restoring divider producing one quotient bit per
//   cycle for both rates in parallel, then the load of the output register.
//   One item is in flight at a time.
// Reset and stalls
//   Synchronous reset sets the window to 1 and clears the state, indices, sums,
//   tick count and output valid; bins are cleared at once through per-entry
//   valid bits, so no clearing pass runs. A result waits in the output register
//   while the receiver stalls; messages are still accepted then, and a following
//   tick holds in its last step until the register frees.

module sliding_window_rate_meter_unit #(
  parameter int MAX_WINDOW = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swrm_pkg::WINDOW_W-1:0]  cfg_wdata,
  swrm_in_if.sink                        item,
  swrm_out_if.source                     result
);
  import swrm_pkg::*;

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  // control and running state
  logic [IDX_W-1:0]       window;
  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       tail;
  logic [IDX_W-1:0]       ticks_seen;
  logic [CNT_W-1:0]       count_sum;
  logic [BYTE_W-1:0]      byte_sum;
  logic [MSG_BYTES_W-1:0] pend_bytes;
  logic                   full_q;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   out_valid;

  // divider lanes
  logic [DIV_W-1:0] div_q_cnt, div_q_byte;
  logic [IDX_W-1:0] div_r_cnt, div_r_byte;
  logic [IDX_W:0]   sh_cnt, sh_byte;
  logic             ge_cnt, ge_byte;

  // ring memory and its port signals
  bin_t             bin_mem [DEPTH];
  logic [DEPTH-1:0] bin_valid;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  bin_t             mem_wdata;
  bin_t             mem_rdata;
  bin_t             rd_fwd_data;
  logic             rd_fwd;
  logic             rd_valid;
  bin_t             bin_rd;

  // combinational helpers
  logic [IDX_W-1:0]  cfg_window;
  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic [CNT_W:0]    msg_add;
  logic [BYTE_W:0]   byte_add;
  bin_t              bin_upd;
  logic [CNT_W:0]    csum_add;
  logic [BYTE_W:0]   bsum_add;
  logic              item_accept;
  logic              out_load;

  assign item_accept = item.valid && item.ready;

  // window value from a configuration write
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_window = IDX_W'(1);
    end else if (int'(cfg_wdata) > MAX_WINDOW) begin
      cfg_window = IDX_W'(MAX_WINDOW);
    end else begin
      cfg_window = IDX_W'(cfg_wdata);
    end
  end

  // ring successors of head and tail
  assign head_next = (head == window) ? '0 : head + IDX_W'(1);
  assign tail_next = (tail == window) ? '0 : tail + IDX_W'(1);

  // bin word seen by the logic: forwarded write, stored entry or cleared entry
  always_comb begin
    if (rd_fwd) begin
      bin_rd = rd_fwd_data;
    end else if (rd_valid) begin
      bin_rd = mem_rdata;
    end else begin
      bin_rd = '0;
    end
  end

  // saturating bin update for a message
  assign msg_add  = {1'b0, bin_rd.msg_cnt} + (CNT_W + 1)'(1);
  assign byte_add = {1'b0, bin_rd.byte_cnt} + (BYTE_W + 1)'(pend_bytes);
  always_comb begin
    bin_upd.msg_cnt  = msg_add[CNT_W] ? '1 : msg_add[CNT_W-1:0];
    bin_upd.byte_cnt = byte_add[BYTE_W] ? '1 : byte_add[BYTE_W-1:0];
  end

  // running sums plus the bin just closed
  assign csum_add = {1'b0, count_sum} + {1'b0, bin_rd.msg_cnt};
  assign bsum_add = {1'b0, byte_sum} + {1'b0, bin_rd.byte_cnt};

  // one restoring division step in each lane
  assign sh_cnt  = {div_r_cnt, div_q_cnt[DIV_W-1]};
  assign sh_byte = {div_r_byte, div_q_byte[DIV_W-1]};
  assign ge_cnt  = (sh_cnt >= {1'b0, window});
  assign ge_byte = (sh_byte >= {1'b0, window});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = (item.req_type == REQ_TICK) ? ST_TICK_SUM : ST_MSG;
        end
      end
      ST_MSG:       state_next = ST_IDLE;
      ST_TICK_SUM:  state_next = ST_TICK_TAIL;
      ST_TICK_TAIL: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine: handshake and memory port
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head;
    mem_wdata  = '0;
    mem_raddr  = head;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
      end
      ST_MSG: begin
        mem_we    = 1'b1;
        mem_wdata = bin_upd;
      end
      ST_TICK_SUM: begin
        mem_we    = 1'b1;
        mem_waddr = head_next;
        mem_raddr = tail;
      end
      ST_TICK_TAIL, ST_DIV: begin
      end
      ST_DONE: begin
        out_load = !out_valid || result.ready;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring memory with one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= bin_mem[mem_raddr];
  end

  // forwarding and entry validity captured alongside the read
  always_ff @(posedge clk) begin
    rd_fwd      <= mem_we && (mem_waddr == mem_raddr);
    rd_fwd_data <= mem_wdata;
    rd_valid    <= bin_valid[mem_raddr];
  end

  // per-entry valid bits: cleared by reset and by a window write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      bin_valid <= '0;
    end else if (mem_we) begin
      bin_valid[mem_waddr] <= 1'b1;
    end
  end

  // window, indices, sums and tick count
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= IDX_W'(1);
      head       <= '0;
      tail       <= '0;
      ticks_seen <= '0;
      count_sum  <= '0;
      byte_sum   <= '0;
    end else if (cfg_we) begin
      window     <= cfg_window;
      head       <= cfg_window - IDX_W'(1);
      tail       <= '0;
      ticks_seen <= '0;
      count_sum  <= '0;
      byte_sum   <= '0;
    end else begin
      unique case (state)
        ST_TICK_SUM: begin
          head      <= head_next;
          count_sum <= csum_add[CNT_W] ? '1 : csum_add[CNT_W-1:0];
          byte_sum  <= bsum_add[BYTE_W] ? '1 : bsum_add[BYTE_W-1:0];
        end
        ST_TICK_TAIL: begin
          if (ticks_seen < window) begin
            ticks_seen <= ticks_seen + IDX_W'(1);
          end
          count_sum <= (bin_rd.msg_cnt > count_sum) ? '0 : count_sum - bin_rd.msg_cnt;
          byte_sum  <= (bin_rd.byte_cnt > byte_sum) ? '0 : byte_sum - bin_rd.byte_cnt;
          tail      <= tail_next;
        end
        ST_IDLE, ST_MSG, ST_DIV, ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // message size held for the write-back
  always_ff @(posedge clk) begin
    if (item_accept) begin
      pend_bytes <= item.msg_bytes;
    end
  end

  // divider lanes and snapshot of the window-full flag
  always_ff @(posedge clk) begin
    if (state == ST_TICK_TAIL) begin
      div_q_cnt  <= DIV_W'({count_sum, {Q_FRAC{1'b0}}});
      div_q_byte <= {byte_sum, {Q_FRAC{1'b0}}};
      div_r_cnt  <= '0;
      div_r_byte <= '0;
      div_cnt    <= '0;
      full_q     <= (ticks_seen >= window);
    end else if (state == ST_DIV) begin
      div_q_cnt  <= {div_q_cnt[DIV_W-2:0], ge_cnt};
      div_q_byte <= {div_q_byte[DIV_W-2:0], ge_byte};
      div_r_cnt  <= ge_cnt ? IDX_W'(sh_cnt - {1'b0, window}) : sh_cnt[IDX_W-1:0];
      div_r_byte <= ge_byte ? IDX_W'(sh_byte - {1'b0, window}) : sh_byte[IDX_W-1:0];
      div_cnt    <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  logic [CNT_W-1:0]       out_msg_total;
  logic [BYTE_W-1:0]      out_byte_total;
  logic [MSG_RATE_W-1:0]  out_msg_rate;
  logic [BYTE_RATE_W-1:0] out_byte_rate;
  logic                   out_full;

  // window totals held from the start of the division
  logic [CNT_W-1:0]  snap_msg_total;
  logic [BYTE_W-1:0] snap_byte_total;

  always_ff @(posedge clk) begin
    if (state == ST_TICK_TAIL) begin
      snap_msg_total  <= count_sum;
      snap_byte_total <= byte_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_msg_total  <= snap_msg_total;
      out_byte_total <= snap_byte_total;
      out_msg_rate   <= div_q_cnt[MSG_RATE_W-1:0];
      out_byte_rate  <= div_q_byte[BYTE_RATE_W-1:0];
      out_full       <= full_q;
    end
  end

  assign result.valid        = out_valid;
  assign result.msg_total    = out_msg_total;
  assign result.byte_total   = out_byte_total;
  assign result.msg_rate_q8  = out_msg_rate;
  assign result.byte_rate_q8 = out_byte_rate;
  assign result.window_full  = out_full;

endmodule
